// File: hdl/fpba_pkg.sv
package fpba_pkg;

  // Fixed widths of the ports.
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int IN_SIZE_W  = 16;
  localparam int OUT_SIZE_W = 16;
  localparam int POLICY_W   = 2;
  localparam int ACTIVE_W   = 5;
  localparam int CFG_DATA_W = 5;

  // Defaults of the top-level parameters.
  localparam int DEF_NUM_BLOCKS = 16;
  localparam int DEF_SIZE_BITS  = 16;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Fit policies. Any other code behaves as first fit.
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic REG_FIT_POLICY    = 1'b0;
  localparam logic REG_ACTIVE_BLOCKS = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIRST;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // Command and configuration broadcast to every cell of the row.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [POLICY_W-1:0] policy;
    logic [ACTIVE_W-1:0] active;
    logic [IDX_W-1:0]    block_index;
  } cell_ctl_t;

endpackage

// File: hdl/fpba_cell.sv
module fpba_cell
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS,
  parameter int CELL_INDEX = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cell_ctl_t                         ctl,
  input  logic [SIZE_BITS-1:0]              sz,
  input  logic                              dec_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     dec_idx,
  input  logic                              in_valid,
  input  logic                              in_found,
  input  logic [SIZE_BITS-1:0]              in_best,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     in_pick,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [SIZE_BITS-1:0]              out_best,
  output logic [$clog2(NUM_BLOCKS)-1:0]     out_pick
);

  localparam int IDX_BITS = $clog2(NUM_BLOCKS);
  localparam int CMP_W    = (IDX_BITS > ACTIVE_W) ? IDX_BITS : ACTIVE_W;
  localparam int ADR_W    = (IDX_BITS > IDX_W) ? IDX_BITS : IDX_W;
  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

  logic [SIZE_BITS-1:0] val;
  logic                 hit;
  logic                 active_ok;
  logic                 better;
  logic                 wr;
  logic                 found_next;
  logic [SIZE_BITS-1:0] best_next;
  logic [IDX_BITS-1:0]  pick_next;

  assign hit       = (ADR_W'(ctl.block_index) == ADR_W'(CELL_INDEX));
  assign active_ok = (CMP_W'(CELL_INDEX) < CMP_W'(ctl.active));

  always_comb begin
    case (ctl.policy)
      POL_BEST:  better = (val < in_best);
      POL_WORST: better = (val > in_best);
      default:   better = 1'b0;
    endcase
  end

  always_comb begin
    found_next = in_found;
    best_next  = in_best;
    pick_next  = in_pick;
    wr         = 1'b0;
    unique case (ctl.cmd)
      CMD_LOAD: begin
        if (hit) begin
          found_next = 1'b1;
          best_next  = sz;
          pick_next  = MY_IDX;
          wr         = 1'b1;
        end
      end
      CMD_READ: begin
        if (hit) begin
          found_next = 1'b1;
          best_next  = val;
          pick_next  = MY_IDX;
        end
      end
      CMD_ALLOC: begin
        // Only a strictly larger block qualifies; ties keep the earlier pick.
        if (active_ok && (val > sz) && (!in_found || better)) begin
          found_next = 1'b1;
          best_next  = val;
          pick_next  = MY_IDX;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (in_valid && wr) begin
        val <= sz;
      end else if (dec_en && (dec_idx == MY_IDX)) begin
        val <= val - sz;
      end
    end
  end

  // The search word holds after it passes, so the last cell keeps the answer.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_found <= found_next;
      out_best  <= best_next;
      out_pick  <= pick_next;
    end
  end

endmodule

// File: hdl/fit_policy_block_allocator.sv
// Block allocator with first, best and worst fit policies.
// Input channel (in_valid/in_ready) takes one word: command, block_index and
// size_value. Output channel (out_valid/out_ready) returns one word per input
// word: granted, chosen_block and remaining_size.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce:
// index 0 is the fit policy, index 1 the number of active blocks.
// Each block's free space lives in its own cell of a row of NUM_BLOCKS cells.
// A search word enters the first cell and moves one cell per cycle through
// the row. The result is registered once the word has left the last cell, and
// a new word is accepted only after the previous result has been registered.
// An allocation reduces the chosen cell in the cycle its result is registered.
// in_ready is low while a command is in the row. A finished result waits in
// the output register; the next command can be accepted meanwhile, but its
// result holds in the row until out_ready frees the register.
// Synchronous reset clears every block to zero, empties the output register
// and sets the policy to first fit with all sixteen blocks active.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [IDX_W-1:0]      block_index,
  input  logic [IN_SIZE_W-1:0]  size_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  granted,
  output logic [IDX_W-1:0]      chosen_block,
  output logic [OUT_SIZE_W-1:0] remaining_size
);

  localparam int IDX_BITS = $clog2(NUM_BLOCKS);

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t              state;
  logic                launch;
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic [SIZE_BITS-1:0] sz_q;
  logic [POLICY_W-1:0] fit_policy;
  logic [ACTIVE_W-1:0] active_blocks;
  cell_ctl_t           ctl;
  logic                slot_free;
  logic                dec_en;
  logic [SIZE_BITS-1:0] rem_full;

  logic                 tok_valid [NUM_BLOCKS+1];
  logic                 tok_found [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] tok_best  [NUM_BLOCKS+1];
  logic [IDX_BITS-1:0]  tok_pick  [NUM_BLOCKS+1];

  assign ctl = '{cmd: cmd_q, policy: fit_policy, active: active_blocks, block_index: idx_q};

  assign tok_valid[0] = launch;
  assign tok_found[0] = 1'b0;
  assign tok_best[0]  = '0;
  assign tok_pick[0]  = '0;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    fpba_cell #(
      .NUM_BLOCKS(NUM_BLOCKS),
      .SIZE_BITS (SIZE_BITS),
      .CELL_INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .sz       (sz_q),
      .dec_en   (dec_en),
      .dec_idx  (tok_pick[NUM_BLOCKS]),
      .in_valid (tok_valid[i]),
      .in_found (tok_found[i]),
      .in_best  (tok_best[i]),
      .in_pick  (tok_pick[i]),
      .out_valid(tok_valid[i+1]),
      .out_found(tok_found[i+1]),
      .out_best (tok_best[i+1]),
      .out_pick (tok_pick[i+1])
    );
  end

  assign in_ready  = (state == IDLE);
  assign slot_free = !out_valid || out_ready;
  assign dec_en    = (state == FINISH) && slot_free && (cmd_q == CMD_ALLOC)
                     && tok_found[NUM_BLOCKS];
  assign rem_full  = (cmd_q == CMD_ALLOC) ? (tok_best[NUM_BLOCKS] - sz_q)
                                          : tok_best[NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      launch        <= 1'b0;
      out_valid     <= 1'b0;
      fit_policy    <= POLICY_RESET;
      active_blocks <= ACTIVE_RESET;
    end else begin
      launch <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FIT_POLICY:    fit_policy    <= cfg_data[POLICY_W-1:0];
          REG_ACTIVE_BLOCKS: active_blocks <= cfg_data[ACTIVE_W-1:0];
        endcase
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            cmd_q  <= command;
            idx_q  <= block_index;
            sz_q   <= SIZE_BITS'(size_value);
            launch <= 1'b1;
            state  <= SCAN;
          end
        end
        SCAN: begin
          if (tok_valid[NUM_BLOCKS]) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            granted   <= tok_found[NUM_BLOCKS];
            if (tok_found[NUM_BLOCKS]) begin
              chosen_block   <= IDX_W'(tok_pick[NUM_BLOCKS]);
              remaining_size <= OUT_SIZE_W'(rem_full);
            end else begin
              chosen_block   <= '0;
              remaining_size <= '0;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: hdl/fpba_checker.sv
module fpba_checker
  import fpba_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  granted,
  input logic [IDX_W-1:0]      chosen_block,
  input logic [OUT_SIZE_W-1:0] remaining_size
);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted)
      && $stable(chosen_block) && $stable(remaining_size))
    else $error("stalled result word changed");

  // One command at a time: the block is busy right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while a command was in flight");

  // A refused allocation or a bad command reports zeros.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> chosen_block == '0 && remaining_size == '0)
    else $error("refused result carries nonzero fields");

  // Reset leaves the block empty and ready.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

// File: test/fit_policy_block_allocator_tb.sv
`timescale 1ns / 100ps

module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  // Codes the package leaves unnamed: a spare policy and an unused command.
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;
  localparam logic [CMD_W-1:0]    CMD_NONE  = 2'd3;
  localparam int BLOCKS = DEF_NUM_BLOCKS;
  localparam int PHASES = 12;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [IDX_W-1:0]     idx;
    logic [IN_SIZE_W-1:0] size;
  } alloc_word_t;

  typedef struct packed {
    logic                  granted;
    logic [IDX_W-1:0]      block;
    logic [OUT_SIZE_W-1:0] left;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] command = '0;
  logic [IDX_W-1:0] block_index = '0;
  logic [IN_SIZE_W-1:0] size_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic granted;
  logic [IDX_W-1:0] chosen_block;
  logic [OUT_SIZE_W-1:0] remaining_size;

  alloc_word_t   pending_words[$];
  alloc_result_t expected_results[$];

  logic [OUT_SIZE_W-1:0] free_space[BLOCKS];
  logic [POLICY_W-1:0]   cur_policy;
  logic [ACTIVE_W-1:0]   cur_active;

  int tx_idle_pct = 20;
  int rx_idle_pct = 64;
  int errors = 0;

  fit_policy_block_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .block_index(block_index), .size_value(size_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted(granted), .chosen_block(chosen_block), .remaining_size(remaining_size)
  );

  always #10 clk = ~clk;

  // Applies one command to the free-space table and returns the answer it gives.
  function automatic alloc_result_t apply_command(alloc_word_t w);
    alloc_result_t r;
    int lim;
    int pick;
    bit found;
    r = '0;
    pick = 0;
    found = 1'b0;
    case (w.cmd) inside
      CMD_LOAD, CMD_READ: begin
        if (w.cmd == CMD_LOAD) free_space[w.idx] = w.size;
        r.granted = 1'b1;
        r.block = w.idx;
        r.left = free_space[w.idx];
      end
      CMD_ALLOC: begin
        lim = (cur_active > BLOCKS) ? BLOCKS : int'(cur_active);
        for (int j = 0; j < lim; j++) begin
          // Only blocks strictly larger than the request qualify.
          if (free_space[j] > w.size) begin
            if (!found) begin
              found = 1'b1;
              pick = j;
            end else if (cur_policy == POL_BEST && free_space[j] < free_space[pick]) begin
              pick = j;
            end else if (cur_policy == POL_WORST && free_space[j] > free_space[pick]) begin
              pick = j;
            end
          end
        end
        if (found) begin
          free_space[pick] = free_space[pick] - w.size;
          r.granted = 1'b1;
          r.block = pick[IDX_W-1:0];
          r.left = free_space[pick];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic push_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [IN_SIZE_W-1:0] size);
    alloc_word_t w;
    w.cmd = cmd;
    w.idx = idx;
    w.size = size;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIT_POLICY) cur_policy = data[POLICY_W-1:0];
    else cur_active = data[ACTIVE_W-1:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Driver: a new word goes out only once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        command <= pending_words[0].cmd;
        block_index <= pending_words[0].idx;
        size_value <= pending_words[0].size;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor: check the result first, so a stray one cannot pair with this edge's word.
  always @(posedge clk) begin
    alloc_word_t w;
    alloc_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result word with nothing expected", $realtime);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (granted !== want.granted)
            report_mismatch("granted", 32'(granted), 32'(want.granted));
          if (chosen_block !== want.block)
            report_mismatch("chosen_block", 32'(chosen_block), 32'(want.block));
          if (remaining_size !== want.left)
            report_mismatch("remaining_size", 32'(remaining_size), 32'(want.left));
        end
      end
      if (in_valid && in_ready) begin
        w.cmd = command;
        w.idx = block_index;
        w.size = size_value;
        expected_results.push_back(apply_command(w));
      end
    end
  end

  initial begin
    logic [POLICY_W-1:0] phase_policy[PHASES];
    logic [ACTIVE_W-1:0] phase_active[PHASES];
    int lim;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [IN_SIZE_W-1:0] size;

    phase_policy = '{POL_BEST, POL_WORST, POL_SPARE, POL_FIRST, POL_BEST, POL_WORST,
                     POL_FIRST, POL_BEST, POL_WORST, POL_BEST, POL_FIRST, POL_WORST};
    phase_active = '{5'd16, 5'd16, 5'd9, 5'd1, 5'd0, 5'd31,
                     5'd16, 5'd2, 5'd5, 5'd16, 5'd12, 5'd31};
    foreach (free_space[i]) free_space[i] = '0;
    cur_policy = POLICY_RESET;
    cur_active = ACTIVE_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset configuration: first fit over all blocks.
    push_word(CMD_READ, 4'd0, 16'h0000);
    push_word(CMD_ALLOC, 4'd0, 16'h0000);
    push_word(CMD_LOAD, 4'd0, 16'h0001);
    push_word(CMD_LOAD, 4'd3, 16'd100);
    push_word(CMD_LOAD, 4'd5, 16'd50);
    push_word(CMD_LOAD, 4'd9, 16'd200);
    push_word(CMD_LOAD, 4'd15, 16'hFFFF);
    push_word(CMD_ALLOC, 4'd7, 16'h0000);
    push_word(CMD_ALLOC, 4'd0, 16'd99);
    push_word(CMD_ALLOC, 4'd0, 16'd100);
    push_word(CMD_ALLOC, 4'd15, 16'hFFFE);
    push_word(CMD_ALLOC, 4'd0, 16'hFFFF);
    push_word(CMD_READ, 4'd15, 16'hFFFF);
    push_word(CMD_READ, 4'd3, 16'h0000);
    push_word(CMD_NONE, 4'd15, 16'hFFFF);
    push_word(CMD_NONE, 4'd0, 16'h0000);
    push_word(CMD_LOAD, 4'd15, 16'h0000);
    push_word(CMD_ALLOC, 4'd0, 16'd49);
    push_word(CMD_READ, 4'd5, 16'h0000);
    push_word(CMD_READ, 4'd9, 16'h0000);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 20;
        rx_idle_pct = 64;
      end else if (p < 8) begin
        tx_idle_pct = 64;
        rx_idle_pct = 20;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(REG_FIT_POLICY, CFG_DATA_W'(phase_policy[p]));
      write_reg(REG_ACTIVE_BLOCKS, CFG_DATA_W'(phase_active[p]));
      lim = (phase_active[p] > BLOCKS) ? BLOCKS : int'(phase_active[p]);

      // Fill the searched blocks so that most allocations have somewhere to go.
      for (int j = 0; j < lim; j++)
        push_word(CMD_LOAD, j[IDX_W-1:0], IN_SIZE_W'($urandom_range(50, 2000)));

      for (int n = 0; n < 45; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) cmd = CMD_LOAD;
        else if (pick < 80) cmd = CMD_ALLOC;
        else if (pick < 95) cmd = CMD_READ;
        else cmd = CMD_NONE;
        if (lim > 0 && $urandom_range(99) < 70) idx = IDX_W'($urandom_range(lim - 1));
        else idx = IDX_W'($urandom_range(BLOCKS - 1));
        pick = $urandom_range(99);
        if (pick < 55) begin
          if (cmd == CMD_LOAD) size = IN_SIZE_W'($urandom_range(0, 1000));
          else size = IN_SIZE_W'($urandom_range(0, 400));
        end else if (pick < 85) size = IN_SIZE_W'($urandom);
        else begin
          case ($urandom_range(3))
            0: size = 16'h0000;
            1: size = 16'h0001;
            2: size = 16'hFFFE;
            default: size = 16'hFFFF;
          endcase
        end
        push_word(cmd, idx, size);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
